/* sv/sbw_pkg.sv */
// Shared constants, register map and controller/datapath interface types.
package sbw_pkg;

   localparam int DEF_MAX_RES             = 2048;
   localparam int DEF_MAX_BYTES_PER_PIXEL = 4;
   localparam int BITS_PER_BYTE           = 8;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int COORD_W    = 12;
   localparam int PBYTES_W   = 3;

   localparam logic [31:0]         RST_FRAME_BASE    = 32'd0;
   localparam logic [COORD_W-1:0]  RST_SCREEN_WIDTH  = 12'd1024;
   localparam logic [COORD_W-1:0]  RST_SCREEN_HEIGHT = 12'd768;
   localparam logic [PBYTES_W-1:0] RST_PIXEL_BYTES   = 3'd1;
   localparam logic [COORD_W-1:0]  RST_ORIGIN_X      = 12'd0;
   localparam logic [COORD_W-1:0]  RST_ORIGIN_Y      = 12'd0;
   localparam logic [COORD_W-1:0]  RST_SPRITE_WIDTH  = 12'd16;
   localparam logic [COORD_W-1:0]  RST_SPRITE_HEIGHT = 12'd16;

   typedef enum logic [2:0] {
      REG_FRAME_BASE    = 3'd0,
      REG_SCREEN_WIDTH  = 3'd1,
      REG_SCREEN_HEIGHT = 3'd2,
      REG_PIXEL_BYTES   = 3'd3,
      REG_ORIGIN_X      = 3'd4,
      REG_ORIGIN_Y      = 3'd5,
      REG_SPRITE_WIDTH  = 3'd6,
      REG_SPRITE_HEIGHT = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [31:0]         frame_base;
      logic [COORD_W-1:0]  screen_width;
      logic [COORD_W-1:0]  screen_height;
      logic [PBYTES_W-1:0] pixel_bytes;
      logic [COORD_W-1:0]  origin_x;
      logic [COORD_W-1:0]  origin_y;
      logic [COORD_W-1:0]  sprite_width;
      logic [COORD_W-1:0]  sprite_height;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic offs;
      logic addr;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic oor;
      logic last;
   } status_type;

endpackage

/* sv/sbw_csr.sv */
// Configuration register file behind the APB-style port.
module sbw_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sbw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sbw_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sbw_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output sbw_pkg::cfg_type                 cfg
);
   import sbw_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_base    <= RST_FRAME_BASE;
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.pixel_bytes   <= RST_PIXEL_BYTES;
         cfg_ff.origin_x      <= RST_ORIGIN_X;
         cfg_ff.origin_y      <= RST_ORIGIN_Y;
         cfg_ff.sprite_width  <= RST_SPRITE_WIDTH;
         cfg_ff.sprite_height <= RST_SPRITE_HEIGHT;
      end else if (wr_en) begin
         case (idx)
            REG_FRAME_BASE:    cfg_ff.frame_base    <= csr_pwdata;
            REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_pwdata[COORD_W-1:0];
            REG_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_pwdata[COORD_W-1:0];
            REG_PIXEL_BYTES:   cfg_ff.pixel_bytes   <= csr_pwdata[PBYTES_W-1:0];
            REG_ORIGIN_X:      cfg_ff.origin_x      <= csr_pwdata[COORD_W-1:0];
            REG_ORIGIN_Y:      cfg_ff.origin_y      <= csr_pwdata[COORD_W-1:0];
            REG_SPRITE_WIDTH:  cfg_ff.sprite_width  <= csr_pwdata[COORD_W-1:0];
            REG_SPRITE_HEIGHT: cfg_ff.sprite_height <= csr_pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_FRAME_BASE:    csr_prdata = cfg_ff.frame_base;
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.screen_height);
         REG_PIXEL_BYTES:   csr_prdata = CSR_DATA_W'(cfg_ff.pixel_bytes);
         REG_ORIGIN_X:      csr_prdata = CSR_DATA_W'(cfg_ff.origin_x);
         REG_ORIGIN_Y:      csr_prdata = CSR_DATA_W'(cfg_ff.origin_y);
         REG_SPRITE_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.sprite_width);
         REG_SPRITE_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.sprite_height);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

/* sv/sbw_ctrl.sv */
// Sequencing state machine: accept, multiply, offset, address, emit bytes.
module sbw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sbw_pkg::cmd_type    cmd,
   input  sbw_pkg::status_type status
);
   import sbw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_OFFS,
      ST_ADDR,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.load = req_valid & req_ready_ff;
      cmd.mul  = (state_ff == ST_MUL);
      cmd.offs = (state_ff == ST_OFFS) & ~status.oor;
      cmd.addr = (state_ff == ST_ADDR);
      cmd.pop  = rsp_valid_ff & rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff     <= ST_MUL;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_MUL: begin
               state_ff <= ST_OFFS;
            end
            ST_OFFS: begin
               if (status.oor) begin
                  state_ff     <= ST_EMIT;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= ST_ADDR;
               end
            end
            ST_ADDR: begin
               state_ff     <= ST_EMIT;
               rsp_valid_ff <= 1'b1;
            end
            ST_EMIT: begin
               if (cmd.pop && status.last) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

/* sv/sbw_datapath.sv */
// Sprite position counters, screen address arithmetic and byte output registers.
module sbw_datapath #(
   parameter int MAX_RES             = sbw_pkg::DEF_MAX_RES,
   parameter int MAX_BYTES_PER_PIXEL = sbw_pkg::DEF_MAX_BYTES_PER_PIXEL
) (
   input  logic                clock,
   input  logic                reset,
   input  sbw_pkg::cfg_type    cfg,
   input  sbw_pkg::cmd_type    cmd,
   output sbw_pkg::status_type status,
   input  logic [31:0]         req_pixel_value,
   output logic [31:0]         rsp_byte_address,
   output logic [7:0]          rsp_byte_value,
   output logic                rsp_out_of_range,
   output logic                rsp_sprite_done,
   output logic                rsp_last
);
   import sbw_pkg::*;

   localparam int CW = $clog2(MAX_RES);
   localparam int BW = $clog2(MAX_BYTES_PER_PIXEL + 1);
   localparam int XW = COORD_W + 1;
   localparam int PW = XW + COORD_W;
   localparam int IW = PW + 1;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [XW-1:0] x_ff;
   logic [XW-1:0] y_ff;
   logic [31:0]   pix_ff;
   logic          done_ff;
   logic          oor_ff;
   logic [PW-1:0] prod_ff;
   logic [IW-1:0] idx_ff;
   logic [31:0]   addr_ff;
   logic [BW-1:0] left_ff;

   logic [XW-1:0]    w_clamp, h_clamp;
   logic [CW-1:0]    w_m1, h_m1;
   logic             row_end, col_done;
   logic [BW-1:0]    nb;
   logic [IW+BW-1:0] scaled;

   always_comb begin
      if (cfg.sprite_width == '0) begin
         w_clamp = XW'(1);
      end else if (XW'(cfg.sprite_width) > XW'(MAX_RES)) begin
         w_clamp = XW'(MAX_RES);
      end else begin
         w_clamp = XW'(cfg.sprite_width);
      end
      if (cfg.sprite_height == '0) begin
         h_clamp = XW'(1);
      end else if (XW'(cfg.sprite_height) > XW'(MAX_RES)) begin
         h_clamp = XW'(MAX_RES);
      end else begin
         h_clamp = XW'(cfg.sprite_height);
      end
      if (cfg.pixel_bytes == '0) begin
         nb = BW'(1);
      end else if (cfg.pixel_bytes > PBYTES_W'(MAX_BYTES_PER_PIXEL)) begin
         nb = BW'(MAX_BYTES_PER_PIXEL);
      end else begin
         nb = BW'(cfg.pixel_bytes);
      end
   end

   assign w_m1     = CW'(w_clamp - XW'(1));
   assign h_m1     = CW'(h_clamp - XW'(1));
   assign row_end  = (col_ff >= w_m1);
   assign col_done = (row_ff >= h_m1);
   assign scaled   = (IW+BW)'(idx_ff) * (IW+BW)'(nb);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.load) begin
         if (row_end) begin
            col_in = '0;
            row_in = col_done ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= XW'(cfg.origin_x) + XW'(col_ff);
         y_ff    <= XW'(cfg.origin_y) + XW'(row_ff);
         pix_ff  <= req_pixel_value;
         done_ff <= row_end & col_done;
      end
      if (cmd.mul) begin
         oor_ff  <= (x_ff >= XW'(cfg.screen_width)) | (y_ff >= XW'(cfg.screen_height));
         prod_ff <= PW'(y_ff) * PW'(cfg.screen_width);
      end
      if (cmd.offs) begin
         idx_ff <= IW'(prod_ff) + IW'(x_ff);
      end
      if (cmd.addr) begin
         addr_ff <= cfg.frame_base + 32'(scaled);
         left_ff <= nb;
      end else if (cmd.pop) begin
         addr_ff <= addr_ff + 32'd1;
         pix_ff  <= pix_ff >> BITS_PER_BYTE;
         left_ff <= left_ff - BW'(1);
      end
   end

   assign status.oor  = oor_ff;
   assign status.last = oor_ff | (left_ff == BW'(1));

   assign rsp_byte_address = oor_ff ? 32'd0 : addr_ff;
   assign rsp_byte_value   = oor_ff ? 8'd0 : pix_ff[BITS_PER_BYTE-1:0];
   assign rsp_out_of_range = oor_ff;
   assign rsp_sprite_done  = done_ff;
   assign rsp_last         = status.last;

endmodule

/* sv/sprite_blit_byte_writer.sv */
// Sprite blit byte writer: takes sprite pixels in row-major order and issues
// frame buffer byte writes, least significant byte first, at
// frame_base + (y*screen_width + x)*pixel_bytes + k; off-screen pixels give one
// word flagged out of range. One pixel at a time: an on-screen pixel passes
// accept and the registered screen-row multiply, offset add and address scale
// steps, then gives one byte word per cycle on the single byte-wide result
// port while the result side does not stall; an off-screen pixel skips the
// offset add and address scale. The user must write configuration through the
// csr_ port only while no pixel is in flight; the block does not enforce this.
module sprite_blit_byte_writer #(
   parameter int MAX_RES             = sbw_pkg::DEF_MAX_RES,
   parameter int MAX_BYTES_PER_PIXEL = sbw_pkg::DEF_MAX_BYTES_PER_PIXEL
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [31:0]                    req_pixel_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_byte_address,
   output logic [7:0]                     rsp_byte_value,
   output logic                           rsp_out_of_range,
   output logic                           rsp_sprite_done,
   output logic                           rsp_last,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sbw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sbw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sbw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sbw_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   sbw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sbw_datapath #(
      .MAX_RES             (MAX_RES),
      .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .status           (status),
      .req_pixel_value  (req_pixel_value),
      .rsp_byte_address (rsp_byte_address),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_sprite_done  (rsp_sprite_done),
      .rsp_last         (rsp_last)
   );

endmodule

/* sv/sbw_checker.sv */
// Port-level assertions for the sprite blit byte writer, bound to the top level.
module sbw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_byte_address,
   input logic [7:0]  rsp_byte_value,
   input logic        rsp_out_of_range,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_address)
         && $stable(rsp_byte_value))
      else $error("result word changed while stalled");

   a_oor_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_last && rsp_byte_address == 32'd0
         && rsp_byte_value == 8'd0)
      else $error("off-screen word not a single zero word");

   a_one_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while results pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("block not busy after accepting a pixel");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("block not free after final word");

endmodule

bind sprite_blit_byte_writer sbw_checker u_sbw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_byte_address (rsp_byte_address),
   .rsp_byte_value   (rsp_byte_value),
   .rsp_out_of_range (rsp_out_of_range),
   .rsp_last         (rsp_last)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the sprite blit byte writer: directed cases, then random blits.
`timescale 1ns / 100ps

module tb_top;
   import sbw_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_SHOWN  = 40;

   typedef struct packed {
      logic [31:0] addr;
      logic [7:0]  data;
      logic        off_screen;
      logic        done;
      logic        last;
   } byte_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_pixel_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [31:0]           rsp_byte_address;
   logic [7:0]            rsp_byte_value;
   logic                  rsp_out_of_range;
   logic                  rsp_sprite_done;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type        shadow_cfg;
   int             col_pos;
   int             row_pos;
   byte_write_type pending_writes[$];
   bit             steady_flow;
   int             rsp_hold;
   int             error_count;
   int             pixels_sent;
   int             words_seen;
   int             off_screen_seen;
   int             sprites_seen;
   int             idle_cycles;

   sprite_blit_byte_writer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_address (rsp_byte_address),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_sprite_done  (rsp_sprite_done),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      if (steady_flow) return 0;
      return $urandom_range(0, 5);
   endfunction

   function automatic logic [31:0] clamp_size(logic [31:0] v, logic [31:0] top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic logic [31:0] with_noise(logic [31:0] v, int width);
      return ($urandom << width) | v;
   endfunction

   function automatic void plot_pixel(logic [31:0] pix);
      logic [31:0]    w;
      logic [31:0]    h;
      logic [31:0]    nb;
      logic [31:0]    x;
      logic [31:0]    y;
      logic [31:0]    base_addr;
      logic           row_end;
      logic           last_row;
      byte_write_type wr;
      w = clamp_size(32'(shadow_cfg.sprite_width), DEF_MAX_RES);
      h = clamp_size(32'(shadow_cfg.sprite_height), DEF_MAX_RES);
      nb = clamp_size(32'(shadow_cfg.pixel_bytes), DEF_MAX_BYTES_PER_PIXEL);
      x = 32'(shadow_cfg.origin_x) + col_pos;
      y = 32'(shadow_cfg.origin_y) + row_pos;
      row_end = col_pos >= w - 1;
      last_row = row_pos >= h - 1;
      wr.done = row_end && last_row;
      if (x >= 32'(shadow_cfg.screen_width) || y >= 32'(shadow_cfg.screen_height)) begin
         wr.addr = '0;
         wr.data = '0;
         wr.off_screen = 1'b1;
         wr.last = 1'b1;
         pending_writes.push_back(wr);
      end else begin
         base_addr = shadow_cfg.frame_base + (y * 32'(shadow_cfg.screen_width) + x) * nb;
         for (int k = 0; k < nb; k++) begin
            wr.addr = base_addr + k;
            wr.data = pix[8*k +: 8];
            wr.off_screen = 1'b0;
            wr.last = (k + 1 == nb);
            pending_writes.push_back(wr);
         end
      end
      if (row_end) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_SHOWN)
         $display("word %0d: %s got %h expected %h (t=%0t)", words_seen, what, got, want, $time);
   endtask

   task automatic send_pixel(input logic [31:0] pix);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_value <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      plot_pixel(pix);
      pixels_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input reg_idx_type idx, input logic wr, input logic [31:0] value);
      logic [31:0] want;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (wr) begin
         case (idx)
            REG_FRAME_BASE:    shadow_cfg.frame_base    = value;
            REG_SCREEN_WIDTH:  shadow_cfg.screen_width  = value[COORD_W-1:0];
            REG_SCREEN_HEIGHT: shadow_cfg.screen_height = value[COORD_W-1:0];
            REG_PIXEL_BYTES:   shadow_cfg.pixel_bytes   = value[PBYTES_W-1:0];
            REG_ORIGIN_X:      shadow_cfg.origin_x      = value[COORD_W-1:0];
            REG_ORIGIN_Y:      shadow_cfg.origin_y      = value[COORD_W-1:0];
            REG_SPRITE_WIDTH:  shadow_cfg.sprite_width  = value[COORD_W-1:0];
            default:           shadow_cfg.sprite_height = value[COORD_W-1:0];
         endcase
      end else begin
         case (idx)
            REG_FRAME_BASE:    want = shadow_cfg.frame_base;
            REG_SCREEN_WIDTH:  want = 32'(shadow_cfg.screen_width);
            REG_SCREEN_HEIGHT: want = 32'(shadow_cfg.screen_height);
            REG_PIXEL_BYTES:   want = 32'(shadow_cfg.pixel_bytes);
            REG_ORIGIN_X:      want = 32'(shadow_cfg.origin_x);
            REG_ORIGIN_Y:      want = 32'(shadow_cfg.origin_y);
            REG_SPRITE_WIDTH:  want = 32'(shadow_cfg.sprite_width);
            default:           want = 32'(shadow_cfg.sprite_height);
         endcase
         if (csr_prdata !== want) report(idx.name(), csr_prdata, want);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      csr_access(idx, 1'b1, value);
   endtask

   task automatic read_all_regs();
      reg_idx_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_access(idx, 1'b0, '0);
         idx = idx.next();
      end
   endtask

   task automatic load_setup(input logic [31:0] base, input logic [11:0] sw, input logic [11:0] sh,
                             input logic [2:0] nb, input logic [11:0] ox, input logic [11:0] oy,
                             input logic [11:0] spw, input logic [11:0] sph);
      csr_write(REG_FRAME_BASE, base);
      csr_write(REG_SCREEN_WIDTH, with_noise(32'(sw), COORD_W));
      csr_write(REG_SCREEN_HEIGHT, with_noise(32'(sh), COORD_W));
      csr_write(REG_PIXEL_BYTES, with_noise(32'(nb), PBYTES_W));
      csr_write(REG_ORIGIN_X, with_noise(32'(ox), COORD_W));
      csr_write(REG_ORIGIN_Y, with_noise(32'(oy), COORD_W));
      csr_write(REG_SPRITE_WIDTH, with_noise(32'(spw), COORD_W));
      csr_write(REG_SPRITE_HEIGHT, with_noise(32'(sph), COORD_W));
   endtask

   task automatic test_register_readback();
      read_all_regs();
      load_setup(32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 3'd7, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      read_all_regs();
      load_setup(32'h0, 12'h0, 12'h0, 3'd0, 12'h0, 12'h0, 12'h0, 12'h0);
      read_all_regs();
   endtask

   task automatic test_pixel_widths();
      logic [2:0] nb;
      load_setup(32'h1000_0000, 12'd64, 12'd64, 3'd1, 12'd3, 12'd5, 12'd2, 12'd2);
      for (int i = 0; i < 8; i++) begin
         nb = i[2:0];
         csr_write(REG_PIXEL_BYTES, 32'(nb));
         send_pixel(i[0] ? 32'hFFFF_FFFF : 32'h8000_0001);
         wait_drained();
      end
      send_pixel(32'h0);
      wait_drained();
   endtask

   task automatic test_screen_edges();
      load_setup(32'h0, 12'd10, 12'd6, 3'd2, 12'd9, 12'd5, 12'd2, 12'd2);
      repeat (4) send_pixel($urandom);
      wait_drained();
      csr_write(REG_SCREEN_WIDTH, 32'd0);
      send_pixel($urandom);
      wait_drained();
      load_setup(32'h0, 12'd2048, 12'd2048, 3'd4, 12'd2047, 12'd2047, 12'd2, 12'd1);
      repeat (2) send_pixel($urandom);
      wait_drained();
      csr_write(REG_ORIGIN_X, 32'hFFF);
      csr_write(REG_ORIGIN_Y, 32'hFFF);
      send_pixel($urandom);
      wait_drained();
   endtask

   task automatic test_address_wrap();
      load_setup(32'hFFFF_FFFE, 12'd16, 12'd16, 3'd4, 12'd0, 12'd0, 12'd1, 12'd1);
      send_pixel(32'hA5C3_3C5A);
      wait_drained();
   endtask

   task automatic test_resize_mid_sprite();
      load_setup(32'h0000_4000, 12'd100, 12'd100, 3'd1, 12'd1, 12'd1, 12'd8, 12'd4);
      repeat (5) send_pixel($urandom);
      wait_drained();
      csr_write(REG_SPRITE_WIDTH, 32'd2);
      send_pixel($urandom);
      wait_drained();
      csr_write(REG_SPRITE_HEIGHT, 32'd0);
      csr_write(REG_SPRITE_WIDTH, 32'd0);
      send_pixel($urandom);
      wait_drained();
      csr_write(REG_SPRITE_WIDTH, 32'hFFF);
      csr_write(REG_SPRITE_HEIGHT, 32'hFFF);
      repeat (2) send_pixel($urandom);
      wait_drained();
   endtask

   task automatic test_random_blits();
      logic [11:0] sw;
      logic [11:0] sh;
      logic [11:0] spw;
      logic [11:0] sph;
      for (int phase = 0; phase < 8; phase++) begin
         steady_flow = (phase % 3 == 2);
         if (phase == 0) begin
            load_setup(32'h0, 12'd1, 12'd1, 3'd0, 12'd0, 12'd0, 12'd1, 12'd1);
         end else if (phase == 1) begin
            load_setup(32'hFFFF_FFFF, 12'd2048, 12'd2048, 3'd7, 12'd2044, 12'd2046, 12'd6, 12'd3);
         end else begin
            sw = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(1, 64));
            sh = 12'($urandom_range(1, 64));
            spw = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 6));
            sph = 12'($urandom_range(0, 5));
            load_setup($urandom, sw, sh, 3'($urandom_range(0, 7)),
                       12'($urandom_range(0, sw + 2)), 12'($urandom_range(0, sh + 2)), spw, sph);
         end
         repeat (13) send_pixel($urandom);
         wait_drained();
      end
      steady_flow = 1'b0;
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      byte_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (rsp_out_of_range) off_screen_seen++;
         if (rsp_sprite_done && rsp_last) sprites_seen++;
         if (pending_writes.size() == 0) begin
            report("unexpected word", rsp_byte_address, '0);
         end else begin
            want = pending_writes.pop_front();
            if (rsp_byte_address !== want.addr)
               report("byte_address", rsp_byte_address, want.addr);
            if (rsp_byte_value !== want.data)
               report("byte_value", 32'(rsp_byte_value), 32'(want.data));
            if (rsp_out_of_range !== want.off_screen)
               report("out_of_range", 32'(rsp_out_of_range), 32'(want.off_screen));
            if (rsp_sprite_done !== want.done)
               report("sprite_done", 32'(rsp_sprite_done), 32'(want.done));
            if (rsp_last !== want.last)
               report("last", 32'(rsp_last), 32'(want.last));
         end
         rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d words pending",
                     idle_cycles, pending_writes.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      shadow_cfg = '{RST_FRAME_BASE, RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_PIXEL_BYTES,
                     RST_ORIGIN_X, RST_ORIGIN_Y, RST_SPRITE_WIDTH, RST_SPRITE_HEIGHT};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_register_readback();
      test_pixel_widths();
      test_screen_edges();
      test_address_wrap();
      test_resize_mid_sprite();
      test_random_blits();
      wait_drained();
      repeat (20) @(posedge clock);
      $display("sent %0d pixels; checked %0d byte words, %0d off screen, %0d sprites finished",
               pixels_sent, words_seen, off_screen_seen, sprites_seen);
      $display("mismatches: %0d", error_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sprite_blit_byte_writer.f */
sv/sbw_pkg.sv
sv/sbw_csr.sv
sv/sbw_ctrl.sv
sv/sbw_datapath.sv
sv/sprite_blit_byte_writer.sv
sv/sbw_checker.sv
tb/sv/tb_top.sv
